// ----- rtl/bfsf_pkg.sv -----
// package: payload types, widths and register codes for the blank frame segment finder
`default_nettype none
package bfsf_pkg;

  localparam int TIME_BITS  = 18;
  localparam int LEVEL_BITS = 16;
  localparam int GAP_BITS   = 8;
  localparam int INDEX_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BRIGHT_MODE     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLUSTER_GAP     = 2'd2;

  localparam logic [LEVEL_BITS-1:0] LEVEL_THRESHOLD_RESET = 16'd4096;
  localparam logic                  BRIGHT_MODE_RESET     = 1'b0;
  localparam logic [GAP_BITS-1:0]   CLUSTER_GAP_RESET     = 8'd5;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_END   = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [TIME_BITS-1:0]  frame_time;
    logic [LEVEL_BITS-1:0] mean_level;
  } item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  period_start;
    logic [TIME_BITS-1:0]  period_end;
    logic [INDEX_BITS-1:0] period_index;
    logic                  last_of_run;
  } period_t;

endpackage
`default_nettype wire

// ----- rtl/blank_frame_segment_finder.sv -----
// top level: blank frame detection, time clustering and cut period output
//
// requests on the item channel carry one frame sample (cmd frame) or the
// end of movie (cmd end) with its time. a request is taken at a rising edge
// with item_valid high and item_stall low, and is held in the input
// register. the cut periods leave on the period channel, taken at an edge
// with period_valid high and period_stall low.
// a request's periods are registered in the output register. throughput:
// one request per cycle while the receiver does not stall and each gives
// at most one period; a request that gives two periods (end of movie
// closing a cluster) holds the input until the hold register has sent its
// period on (one output register plus one hold register). configuration writes
// on cfg_valid/cfg_ready are always taken; the user must make them while the
// block is idle (the block does not enforce it). register indexes follow the
// list in the package. reset (rst, synchronous) empties both channels, returns
// the registers to their defaults and the clusters to the seed cluster at
// time 0. while the receiver stalls, the output and hold registers keep their
// periods and item_stall rises as soon as a request waits in the input register.
`default_nettype none
module blank_frame_segment_finder
  import bfsf_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      item_valid,
  output      logic                      item_stall,
  input  wire item_t                     item,
  output      logic                      period_valid,
  input  wire logic                      period_stall,
  output      period_t                   period,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [LEVEL_BITS-1:0] level_threshold;
  logic                  bright_mode;
  logic [GAP_BITS-1:0]   cluster_gap;

  logic [TIME_BITS-1:0]  prev_cluster_first, prev_cluster_first_next;
  logic [TIME_BITS-1:0]  cur_cluster_first, cur_cluster_first_next;
  logic [TIME_BITS-1:0]  cur_cluster_last, cur_cluster_last_next;
  logic                  have_prev_cluster, have_prev_cluster_next;
  logic [INDEX_BITS-1:0] period_count, period_count_next;

  logic    req_valid;
  item_t   req;
  logic    hold_valid;
  period_t hold;

  logic                  proceed;
  logic                  blank;
  logic [TIME_BITS-1:0]  span;
  logic                  join_cluster;
  logic                  emit_close;
  logic                  emit_end;
  logic [TIME_BITS-1:0]  mid_prev_first;
  logic [TIME_BITS-1:0]  mid_cur_first;
  logic [TIME_BITS-1:0]  mid_cur_last;
  logic                  mid_have_prev;
  period_t               res_close;
  period_t               res_end;
  period_t               res_first;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold <= LEVEL_THRESHOLD_RESET;
      bright_mode     <= BRIGHT_MODE_RESET;
      cluster_gap     <= CLUSTER_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEVEL_THRESHOLD: level_threshold <= cfg_data;
        CFG_BRIGHT_MODE:     bright_mode     <= cfg_data[0];
        CFG_CLUSTER_GAP:     cluster_gap     <= cfg_data[GAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // room for two periods: hold register free and output register empty or leaving
  assign proceed    = !hold_valid && (!period_valid || !period_stall);
  assign item_stall = req_valid && !proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      req_valid <= 1'b1;
    end else if (proceed) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      req <= item;
    end
  end

  // blank test and cluster update
  always_comb begin
    if (req.cmd == CMD_END) begin
      blank = 1'b1;
    end else if (bright_mode) begin
      blank = req.mean_level > level_threshold;
    end else begin
      blank = req.mean_level < level_threshold;
    end

    if (req.frame_time >= cur_cluster_last) begin
      span = req.frame_time - cur_cluster_last;
    end else begin
      span = cur_cluster_last - req.frame_time;
    end
    join_cluster = span <= {{(TIME_BITS-GAP_BITS){1'b0}}, cluster_gap};

    mid_prev_first = prev_cluster_first;
    mid_cur_first  = cur_cluster_first;
    mid_cur_last   = cur_cluster_last;
    mid_have_prev  = have_prev_cluster;
    emit_close     = 1'b0;
    if (blank) begin
      if (join_cluster) begin
        mid_cur_last = req.frame_time;
      end else begin
        emit_close     = have_prev_cluster;
        mid_prev_first = cur_cluster_first;
        mid_have_prev  = 1'b1;
        mid_cur_first  = req.frame_time;
        mid_cur_last   = req.frame_time;
      end
    end
    emit_end = (req.cmd == CMD_END) && mid_have_prev;

    res_close.period_start = prev_cluster_first;
    res_close.period_end   = cur_cluster_last;
    res_close.period_index = period_count;
    res_close.last_of_run  = !emit_end;

    res_end.period_start = mid_prev_first;
    res_end.period_end   = mid_cur_last;
    res_end.period_index = period_count + {{(INDEX_BITS-1){1'b0}}, emit_close};
    res_end.last_of_run  = 1'b1;

    res_first = emit_close ? res_close : res_end;

    if (req.cmd == CMD_END) begin
      prev_cluster_first_next = '0;
      cur_cluster_first_next  = '0;
      cur_cluster_last_next   = '0;
      have_prev_cluster_next  = 1'b0;
      period_count_next       = '0;
    end else begin
      prev_cluster_first_next = mid_prev_first;
      cur_cluster_first_next  = mid_cur_first;
      cur_cluster_last_next   = mid_cur_last;
      have_prev_cluster_next  = mid_have_prev;
      period_count_next       = period_count + {{(INDEX_BITS-1){1'b0}}, emit_close};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cluster_first <= '0;
      cur_cluster_first  <= '0;
      cur_cluster_last   <= '0;
      have_prev_cluster  <= 1'b0;
      period_count       <= '0;
    end else if (req_valid && proceed) begin
      prev_cluster_first <= prev_cluster_first_next;
      cur_cluster_first  <= cur_cluster_first_next;
      cur_cluster_last   <= cur_cluster_last_next;
      have_prev_cluster  <= have_prev_cluster_next;
      period_count       <= period_count_next;
    end
  end

  // output register and hold register for the second period
  always_ff @(posedge clk) begin
    if (rst) begin
      period_valid <= 1'b0;
      hold_valid   <= 1'b0;
    end else if (req_valid && proceed) begin
      period_valid <= emit_close || emit_end;
      hold_valid   <= emit_close && emit_end;
    end else if (hold_valid && (!period_valid || !period_stall)) begin
      period_valid <= 1'b1;
      hold_valid   <= 1'b0;
    end else if (period_valid && !period_stall) begin
      period_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && proceed) begin
      period <= res_first;
      hold   <= res_end;
    end else if (hold_valid && (!period_valid || !period_stall)) begin
      period <= hold;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_blank_frame_segment_finder.sv -----
// testbench: randomised frame and end-of-movie requests checked against a cut period predictor
`timescale 1ns / 100ps
module tb_blank_frame_segment_finder;
  import bfsf_pkg::*;

  localparam int TIME_MAX    = (1 << TIME_BITS) - 1;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    period_valid;
  logic    period_stall = 1'b0;
  period_t period;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_LEVEL_THRESHOLD;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  blank_frame_segment_finder dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .period_valid (period_valid),
    .period_stall (period_stall),
    .period       (period),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // predictor copy of the registers and cluster state
  logic [LEVEL_BITS-1:0] thr_level = LEVEL_THRESHOLD_RESET;
  logic                  bright_on = BRIGHT_MODE_RESET;
  logic [GAP_BITS-1:0]   join_gap  = CLUSTER_GAP_RESET;

  logic [TIME_BITS-1:0]  seg_prev_first = '0;
  logic [TIME_BITS-1:0]  seg_cur_first  = '0;
  logic [TIME_BITS-1:0]  seg_cur_last   = '0;
  logic                  seg_have_prev  = 1'b0;
  logic [INDEX_BITS-1:0] seg_count      = '0;

  item_t   pending_items[$];
  period_t expected_periods[$];
  period_t item_periods[$];

  int stim_weight = 0;
  int period_errors = 0;
  int cycle_count = 0;
  int feed_wait = 0;
  int feed_calm = 0;
  int stall_left = 0;
  int out_calm = 0;

  function automatic bit frame_is_blank(input logic [LEVEL_BITS-1:0] lvl);
    return bright_on ? (lvl > thr_level) : (lvl < thr_level);
  endfunction

  function automatic void open_period(input logic [TIME_BITS-1:0] first,
                                      input logic [TIME_BITS-1:0] last);
    period_t p;
    p.period_start = first;
    p.period_end   = last;
    p.period_index = seg_count;
    p.last_of_run  = 1'b0;
    item_periods = {item_periods, p};
    seg_count = seg_count + 1'b1;
  endfunction

  function automatic void note_blank(input logic [TIME_BITS-1:0] t);
    logic [TIME_BITS-1:0] span;
    span = (t >= seg_cur_last) ? t - seg_cur_last : seg_cur_last - t;
    if (span <= join_gap) begin
      seg_cur_last = t;
      return;
    end
    if (seg_have_prev) open_period(seg_prev_first, seg_cur_last);
    seg_prev_first = seg_cur_first;
    seg_have_prev  = 1'b1;
    seg_cur_first  = t;
    seg_cur_last   = t;
  endfunction

  function automatic void predict_periods(input item_t req);
    period_t p;
    item_periods.delete();
    if (req.cmd == CMD_FRAME) begin
      if (frame_is_blank(req.mean_level)) note_blank(req.frame_time);
    end else begin
      note_blank(req.frame_time);
      if (seg_have_prev) open_period(seg_prev_first, seg_cur_last);
      seg_prev_first = '0;
      seg_cur_first  = '0;
      seg_cur_last   = '0;
      seg_have_prev  = 1'b0;
      seg_count      = '0;
    end
    foreach (item_periods[i]) begin
      p = item_periods[i];
      p.last_of_run = (i == item_periods.size() - 1);
      expected_periods = {expected_periods, p};
    end
  endfunction

  // per-item wait, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : feed_requests
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!(item_valid && item_stall)) begin
      if (item_valid) predict_periods(item);
      if (feed_wait > 0) begin
        feed_wait--;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
        feed_wait = draw_wait(feed_calm);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : take_periods
    period_t want;
    if (rst) begin
      period_stall <= 1'b0;
    end else begin
      if (period_valid && !period_stall) begin
        if (expected_periods.size() == 0) begin
          period_errors++;
          if (period_errors <= 10)
            $display("unexpected period: start %0d end %0d index %0d last %0b",
                     period.period_start, period.period_end, period.period_index,
                     period.last_of_run);
        end else begin
          want = expected_periods.pop_front();
          if (period.period_start !== want.period_start ||
              period.period_end !== want.period_end ||
              period.period_index !== want.period_index ||
              period.last_of_run !== want.last_of_run) begin
            period_errors++;
            if (period_errors <= 10)
              $display("period mismatch: expected %0d..%0d #%0d last %0b, got %0d..%0d #%0d last %0b",
                       want.period_start, want.period_end, want.period_index,
                       want.last_of_run, period.period_start, period.period_end,
                       period.period_index, period.last_of_run);
          end
        end
        stall_left = draw_wait(out_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        period_stall <= 1'b1;
      end else begin
        period_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LEVEL_THRESHOLD: thr_level = val[LEVEL_BITS-1:0];
      CFG_BRIGHT_MODE:     bright_on = val[0];
      CFG_CLUSTER_GAP:     join_gap  = val[GAP_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic push_item(input logic c, input int t, input int lvl);
    item_t req;
    req.cmd        = c;
    req.frame_time = t[TIME_BITS-1:0];
    req.mean_level = lvl[LEVEL_BITS-1:0];
    pending_items = {pending_items, req};
    if (c == CMD_END || frame_is_blank(req.mean_level)) stim_weight++;
  endtask

  function automatic int clamp_time(input int t);
    if (t < 0) return 0;
    if (t > TIME_MAX) return TIME_MAX;
    return t;
  endfunction

  function automatic int pick_level(input bit want_blank);
    if ($urandom_range(0, 9) == 0) return int'(thr_level);
    if (!bright_on) begin
      if (want_blank && thr_level != 0) return $urandom_range(0, thr_level - 1);
      if (!want_blank) return $urandom_range(thr_level, 16'hFFFF);
    end else begin
      if (want_blank && thr_level != 16'hFFFF) return $urandom_range(thr_level + 1, 16'hFFFF);
      if (!want_blank) return $urandom_range(0, thr_level);
    end
    return $urandom_range(0, 16'hFFFF);
  endfunction

  task automatic add_movie();
    int frames;
    int t;
    int step;
    int pick;
    frames = $urandom_range(2, 30);
    t = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 30) : $urandom_range(0, TIME_MAX);
    repeat (frames) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) step = $urandom_range(0, join_gap);
      else if (pick < 16) step = join_gap + $urandom_range(0, 1);
      else if (pick < 19) step = join_gap + $urandom_range(2, 600);
      else step = 0 - int'($urandom_range(0, 2 * join_gap + 2));
      t = clamp_time(t + step);
      push_item(CMD_FRAME, t, pick_level($urandom_range(0, 9) < 4));
    end
    push_item(CMD_END, clamp_time(t + $urandom_range(0, 2 * join_gap + 2)),
              $urandom_range(0, 16'hFFFF));
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || item_valid || expected_periods.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int thr, input int bright, input int gap, input int weight);
    write_reg(CFG_LEVEL_THRESHOLD, thr[CFG_DATA_BITS-1:0]);
    write_reg(CFG_BRIGHT_MODE, bright[CFG_DATA_BITS-1:0]);
    write_reg(CFG_CLUSTER_GAP, gap[CFG_DATA_BITS-1:0]);
    @(negedge clk);
    stim_weight = 0;
    while (stim_weight < weight) begin
      if ($urandom_range(0, 6) == 0)
        push_item(($urandom_range(0, 9) == 0) ? CMD_END : CMD_FRAME,
                  $urandom_range(0, TIME_MAX), $urandom_range(0, 16'hFFFF));
      else
        add_movie();
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset register values: threshold 4096, dark mode, gap 5
    push_item(CMD_FRAME, 0, 0);
    push_item(CMD_FRAME, 3, 4096);
    push_item(CMD_FRAME, 5, 4095);
    push_item(CMD_FRAME, 11, 0);
    push_item(CMD_FRAME, 11, 4095);
    push_item(CMD_FRAME, 8, 0);
    push_item(CMD_FRAME, 20, 0);
    push_item(CMD_FRAME, TIME_MAX, 16'hFFFF);
    push_item(CMD_FRAME, TIME_MAX, 0);
    push_item(CMD_END, TIME_MAX, 0);
    push_item(CMD_END, 0, 16'hFFFF);
    push_item(CMD_FRAME, 10, 0);
    push_item(CMD_END, 100, 0);
    push_item(CMD_FRAME, 3, 1);
    push_item(CMD_END, 4, 0);
    push_item(CMD_FRAME, 6, 0);
    push_item(CMD_FRAME, 0, 0);
    push_item(CMD_END, 0, 0);
    push_item(CMD_END, TIME_MAX, 0);
    push_item(CMD_FRAME, 7, 16'hFFFF);
    drain();

    run_phase(16'hFFFF, 0, 0, 110);
    run_phase(0, 1, 255, 110);
    run_phase(0, 0, $urandom_range(0, 255), 8);
    run_phase(16'hFFFF, 1, $urandom_range(0, 255), 8);
    run_phase($urandom_range(0, 16'hFFFF), 0, $urandom_range(0, 255), 160);
    run_phase($urandom_range(0, 16'hFFFF), 1, $urandom_range(0, 255), 160);

    if (period_errors == 0 && expected_periods.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bfsf_pkg.sv
rtl/blank_frame_segment_finder.sv
tb/sv/tb_blank_frame_segment_finder.sv
